[rtl/qvr_pkg.sv]
`timescale 1ns / 1ps
package qvr_pkg;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] vec_x;
      logic signed [15:0] vec_y;
      logic signed [15:0] vec_z;
   } qvr_req_type;

   typedef struct packed {
      logic signed [15:0] rot_x;
      logic signed [15:0] rot_y;
      logic signed [15:0] rot_z;
      logic               clipped;
   } qvr_rsp_type;

   typedef struct packed {
      logic prod1;
      logic sum1;
      logic prod2;
      logic sum2;
      logic sat;
   } qvr_stage_en_type;

   localparam int unsigned NumStages = 5;
   localparam int unsigned PWidth    = 33;
   localparam int unsigned RWidth    = 50;

endpackage

[rtl/qvr_datapath.sv]
`timescale 1ns / 1ps
module qvr_datapath
   import qvr_pkg::*;
(
   input  logic             clock,
   input  qvr_stage_en_type stage_en,
   input  qvr_req_type      req_data,
   output qvr_rsp_type      rsp_data
);

   localparam int unsigned FracBits = 28;
   localparam logic signed [RWidth-1:0] RndHalf = RWidth'(64'sd1 <<< (FracBits - 1));
   localparam logic signed [RWidth-1:0] SatHi   = RWidth'(64'sd1 <<< (FracBits + 15));
   localparam logic signed [RWidth-1:0] SatLo   = -SatHi;

   typedef struct packed {
      logic signed [15:0] val;
      logic               clip;
   } sat_type;

   function automatic sat_type round_sat(input logic signed [RWidth-1:0] r);
      sat_type res;
      if (r >= SatHi) begin
         res.val  = 16'sh7fff;
         res.clip = 1'b1;
      end else if (r < SatLo) begin
         res.val  = 16'sh8000;
         res.clip = 1'b1;
      end else begin
         res.val  = r[FracBits+15:FracBits];
         res.clip = 1'b0;
      end
      return res;
   endfunction

   // Stage 1: q times v products.
   logic signed [31:0] bvx_ff, cvy_ff, dvz_ff, avx_ff, cvz_ff, dvy_ff;
   logic signed [31:0] avy_ff, dvx_ff, bvz_ff, avz_ff, bvy_ff, cvx_ff;
   logic signed [15:0] qa1_ff, qb1_ff, qc1_ff, qd1_ff;

   always_ff @(posedge clock) begin
      if (stage_en.prod1) begin
         bvx_ff <= req_data.quat_x * req_data.vec_x;
         cvy_ff <= req_data.quat_y * req_data.vec_y;
         dvz_ff <= req_data.quat_z * req_data.vec_z;
         avx_ff <= req_data.quat_w * req_data.vec_x;
         cvz_ff <= req_data.quat_y * req_data.vec_z;
         dvy_ff <= req_data.quat_z * req_data.vec_y;
         avy_ff <= req_data.quat_w * req_data.vec_y;
         dvx_ff <= req_data.quat_z * req_data.vec_x;
         bvz_ff <= req_data.quat_x * req_data.vec_z;
         avz_ff <= req_data.quat_w * req_data.vec_z;
         bvy_ff <= req_data.quat_x * req_data.vec_y;
         cvx_ff <= req_data.quat_y * req_data.vec_x;
         qa1_ff <= req_data.quat_w;
         qb1_ff <= req_data.quat_x;
         qc1_ff <= req_data.quat_y;
         qd1_ff <= req_data.quat_z;
      end
   end

   // Stage 2: the intermediate quaternion p = q * (0, v).
   logic signed [PWidth-1:0] pw_ff, px_ff, py_ff, pz_ff;
   logic signed [15:0]       qa2_ff, qb2_ff, qc2_ff, qd2_ff;

   always_ff @(posedge clock) begin
      if (stage_en.sum1) begin
         pw_ff  <= -PWidth'(bvx_ff) - PWidth'(cvy_ff) - PWidth'(dvz_ff);
         px_ff  <=  PWidth'(avx_ff) + PWidth'(cvz_ff) - PWidth'(dvy_ff);
         py_ff  <=  PWidth'(avy_ff) + PWidth'(dvx_ff) - PWidth'(bvz_ff);
         pz_ff  <=  PWidth'(avz_ff) + PWidth'(bvy_ff) - PWidth'(cvx_ff);
         qa2_ff <= qa1_ff;
         qb2_ff <= qb1_ff;
         qc2_ff <= qc1_ff;
         qd2_ff <= qd1_ff;
      end
   end

   // Stage 3: p times conjugate products.
   localparam int unsigned MWidth = PWidth + 16;
   logic signed [MWidth-1:0] pwb_ff, pwc_ff, pwd_ff, pxa_ff, pxd_ff, pxc_ff;
   logic signed [MWidth-1:0] pyd_ff, pya_ff, pyb_ff, pzc_ff, pzb_ff, pza_ff;

   always_ff @(posedge clock) begin
      if (stage_en.prod2) begin
         pwb_ff <= pw_ff * qb2_ff;
         pwc_ff <= pw_ff * qc2_ff;
         pwd_ff <= pw_ff * qd2_ff;
         pxa_ff <= px_ff * qa2_ff;
         pxd_ff <= px_ff * qd2_ff;
         pxc_ff <= px_ff * qc2_ff;
         pyd_ff <= py_ff * qd2_ff;
         pya_ff <= py_ff * qa2_ff;
         pyb_ff <= py_ff * qb2_ff;
         pzc_ff <= pz_ff * qc2_ff;
         pzb_ff <= pz_ff * qb2_ff;
         pza_ff <= pz_ff * qa2_ff;
      end
   end

   // Stage 4: vector part of the product, with the rounding offset added.
   logic signed [RWidth-1:0] rx_ff, ry_ff, rz_ff;

   always_ff @(posedge clock) begin
      if (stage_en.sum2) begin
         rx_ff <= -RWidth'(pwb_ff) + RWidth'(pxa_ff) - RWidth'(pyd_ff) + RWidth'(pzc_ff)
                  + RndHalf;
         ry_ff <= -RWidth'(pwc_ff) + RWidth'(pxd_ff) + RWidth'(pya_ff) - RWidth'(pzb_ff)
                  + RndHalf;
         rz_ff <= -RWidth'(pwd_ff) - RWidth'(pxc_ff) + RWidth'(pyb_ff) + RWidth'(pza_ff)
                  + RndHalf;
      end
   end

   // Stage 5: saturation into the output register.
   sat_type     sx, sy, sz;
   qvr_rsp_type rsp_in;
   qvr_rsp_type rsp_ff;

   always_comb begin
      sx             = round_sat(rx_ff);
      sy             = round_sat(ry_ff);
      sz             = round_sat(rz_ff);
      rsp_in.rot_x   = sx.val;
      rsp_in.rot_y   = sy.val;
      rsp_in.rot_z   = sz.val;
      rsp_in.clipped = sx.clip | sy.clip | sz.clip;
   end

   always_ff @(posedge clock) begin
      if (stage_en.sat) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[rtl/quaternion_vector_rotate_top.sv]
// A request passes the product, sum, product, sum and saturation stages in turn.
// Throughput: one transaction per cycle while rsp_ready is high; each stage moves
// if the one after it is empty or moving, so back-pressure squeezes out bubbles.
// Reset clears all stage valid bits; the datapath registers are not reset.
`timescale 1ns / 1ps
module quaternion_vector_rotate_top
   import qvr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  qvr_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output qvr_rsp_type rsp_data
);

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] move;
   qvr_stage_en_type     stage_en;

   always_comb begin
      move[NumStages-1] = !valid_ff[NumStages-1] || rsp_ready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         move[k] = !valid_ff[k] || move[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (move[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NumStages; k++) begin
            if (move[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign stage_en.prod1 = move[0] && req_valid;
   assign stage_en.sum1  = move[1] && valid_ff[0];
   assign stage_en.prod2 = move[2] && valid_ff[1];
   assign stage_en.sum2  = move[3] && valid_ff[2];
   assign stage_en.sat   = move[4] && valid_ff[3];

   assign req_ready = move[0];
   assign rsp_valid = valid_ff[NumStages-1];

   qvr_datapath u_datapath (
      .clock    (clock),
      .stage_en (stage_en),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

[rtl/qvr_checker.sv]
`timescale 1ns / 1ps
module qvr_checker
   import qvr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input qvr_rsp_type rsp_data
);

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Response changed while stalled.");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Response valid right after reset.");

   a_no_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("Request stalled although responses drain.");

   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clipped |->
         rsp_data.rot_x == 16'sh7fff || rsp_data.rot_x == 16'sh8000 ||
         rsp_data.rot_y == 16'sh7fff || rsp_data.rot_y == 16'sh8000 ||
         rsp_data.rot_z == 16'sh7fff || rsp_data.rot_z == 16'sh8000)
      else $error("Clip flag without a saturated component.");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      $past(req_fire, 5) && $past(rsp_ready, 1) && $past(rsp_ready, 2) &&
      $past(rsp_ready, 3) && $past(rsp_ready, 4) && !$past(reset, 1) &&
      !$past(reset, 2) && !$past(reset, 3) && !$past(reset, 4) && !$past(reset, 5)
      |-> rsp_valid)
      else $error("Transaction did not arrive after five free-flowing cycles.");

endmodule

bind quaternion_vector_rotate_top qvr_checker u_qvr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
